FILE: sv/fptc_pkg.sv
// Shared types, operation codes and constants for the fixed-point time converter.
package fptc_pkg;

  typedef enum logic [2:0] {
    OP_MUL         = 3'd0,
    OP_TO_NS       = 3'd1,
    OP_FROM_NS     = 3'd2,
    OP_TO_US       = 3'd3,
    OP_FROM_US     = 3'd4,
    OP_US_TO_FIXED = 3'd5
  } op_t;

  localparam logic [31:0] NS_PER_S = 32'd1000000000;
  localparam logic [31:0] US_PER_S = 32'd1000000;

  localparam int SUBSEC_W = 30;
  localparam int PROD_W   = 96;

  // A join computes floor(n * 2^32 / scale) as floor(n * K / 2^shift) with K rounded
  // up. The power of two in each scale is taken out first, which leaves an odd
  // divisor small enough that the rounding error never reaches the next integer
  // for any 32-bit n. One thousand million is 2^9 * 1953125; one million is
  // 2^6 * 15625.
  localparam int NS_SHIFT = 53;
  localparam int US_SHIFT = 46;

  localparam logic [127:0] NS_RECIP_FULL =
    ((128'd1 << (23 + NS_SHIFT)) + 128'd1953124) / 128'd1953125;
  localparam logic [127:0] US_RECIP_FULL =
    ((128'd1 << (26 + US_SHIFT)) + 128'd15624) / 128'd15625;

  localparam logic [63:0] NS_RECIP = NS_RECIP_FULL[63:0];
  localparam logic [63:0] US_RECIP = US_RECIP_FULL[63:0];

  // Bits of the sum above the fraction hold the whole units carried into seconds.
  localparam int NS_QUOT_W = PROD_W - 32 - NS_SHIFT;
  localparam int US_QUOT_W = PROD_W - 32 - US_SHIFT;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [31:0] seconds;
    logic [31:0] subsec;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [31:0] seconds;
  } prod_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [PROD_W-1:0] total;
    logic [31:0]       seconds;
  } sum_t;

  typedef struct packed {
    logic [63:0]         fixed_value;
    logic [31:0]         seconds;
    logic [SUBSEC_W-1:0] subsec;
  } result_t;

endpackage

FILE: sv/fixed_point_time_converter_unit.sv
// Top level of the 32.32 fixed-point time converter: input register and three stages.
// An accepted item passes through the input, product, sum and result registers in turn
// to out_valid. Throughput is one item per cycle while out_stall is low, set by the four stage
// registers (input, 32 by 32 multipliers, 96-bit adder, result), each holding one item.
// Reset clears only the stage valid bits; the data registers are left as they are.
module fixed_point_time_converter_unit import fptc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          opcode,
  input  logic [63:0]         operand_a,
  input  logic [63:0]         operand_b,
  input  logic [31:0]         in_seconds,
  input  logic [31:0]         in_subsec,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         fixed_value,
  output logic [31:0]         out_seconds,
  output logic [SUBSEC_W-1:0] out_subsec
);

  // One valid bit per stage. A stage may load when it is empty or when the stage
  // after it can take its item in the same cycle, so bubbles close up even while
  // the output is stalled.
  logic     v0, v1, v2, v3;
  logic     ready0, ready1, ready2, ready3;

  in_item_t item;
  prod_t    prod;
  sum_t     sum;
  result_t  result;

  assign ready3 = !v3 || !out_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign ready0 = !v0 || ready1;

  assign in_stall = !ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready0) begin
        v0 <= in_valid;
      end
      if (ready1) begin
        v1 <= v0;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  // The input register captures the raw fields of each accepted item.
  always_ff @(posedge clk) begin
    if (ready0 && in_valid) begin
      item.opcode    <= opcode;
      item.operand_a <= operand_a;
      item.operand_b <= operand_b;
      item.seconds   <= in_seconds;
      item.subsec    <= in_subsec;
    end
  end

  // Multiplication forms the four partial products of the 64 by 64 product. A split
  // uses one of them for fraction times scale. A join or a microsecond conversion
  // multiplies its 32-bit count by a 64-bit reciprocal in two halves.
  fptc_mul_stage u_mul (
    .clk  (clk),
    .load (ready1),
    .item (item),
    .prod (prod)
  );

  fptc_sum_stage u_sum (
    .clk  (clk),
    .load (ready2),
    .prod (prod),
    .sum  (sum)
  );

  // The final stage takes bits 95:32 for a product, bits 61:32 for a split, and for
  // a division the fraction and quotient fields above the reciprocal's shift. The
  // quotient is the number of whole seconds carried over, added to the seconds
  // input modulo 2^32.
  fptc_format_stage u_format (
    .clk    (clk),
    .load   (ready3),
    .sum    (sum),
    .result (result)
  );

  assign out_valid   = v3;
  assign fixed_value = result.fixed_value;
  assign out_seconds = result.seconds;
  assign out_subsec  = result.subsec;

endmodule

FILE: sv/fptc_mul_stage.sv
// Operand selection and the four 32 by 32 partial-product multipliers.
module fptc_mul_stage import fptc_pkg::*; (
  input  logic     clk,
  input  logic     load,
  input  in_item_t item,
  output prod_t    prod
);

  logic [31:0] x0, y0, x1, y1, x2, y2, x3, y3;
  logic [31:0] a_lo, a_hi, b_lo, b_hi;
  prod_t       prod_next;

  assign a_lo = item.operand_a[31:0];
  assign a_hi = item.operand_a[63:32];
  assign b_lo = item.operand_b[31:0];
  assign b_hi = item.operand_b[63:32];

  always_comb begin
    x0 = '0; y0 = '0; x1 = '0; y1 = '0;
    x2 = '0; y2 = '0; x3 = '0; y3 = '0;
    prod_next.opcode  = item.opcode;
    prod_next.seconds = '0;
    unique case (op_t'(item.opcode))
      OP_MUL: begin
        x0 = a_lo; y0 = b_lo;
        x1 = a_hi; y1 = b_lo;
        x2 = a_lo; y2 = b_hi;
        x3 = a_hi; y3 = b_hi;
      end
      OP_TO_NS: begin
        x0 = a_lo; y0 = NS_PER_S;
        prod_next.seconds = a_hi;
      end
      OP_TO_US: begin
        x0 = a_lo; y0 = US_PER_S;
        prod_next.seconds = a_hi;
      end
      OP_FROM_NS: begin
        x0 = item.subsec; y0 = NS_RECIP[31:0];
        x1 = item.subsec; y1 = NS_RECIP[63:32];
        prod_next.seconds = item.seconds;
      end
      OP_FROM_US: begin
        x0 = item.subsec; y0 = US_RECIP[31:0];
        x1 = item.subsec; y1 = US_RECIP[63:32];
        prod_next.seconds = item.seconds;
      end
      OP_US_TO_FIXED: begin
        x0 = a_lo; y0 = US_RECIP[31:0];
        x1 = a_lo; y1 = US_RECIP[63:32];
      end
      default: begin
      end
    endcase
    prod_next.p0 = {32'd0, x0} * {32'd0, y0};
    prod_next.p1 = {32'd0, x1} * {32'd0, y1};
    prod_next.p2 = {32'd0, x2} * {32'd0, y2};
    prod_next.p3 = {32'd0, x3} * {32'd0, y3};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

FILE: sv/fptc_sum_stage.sv
// Adds the aligned partial products into one 96-bit sum.
module fptc_sum_stage import fptc_pkg::*; (
  input  logic  clk,
  input  logic  load,
  input  prod_t prod,
  output sum_t  sum
);

  sum_t sum_next;

  always_comb begin
    sum_next.opcode  = prod.opcode;
    sum_next.seconds = prod.seconds;
    sum_next.total   = {32'd0, prod.p0}
                     + {prod.p1, 32'd0}
                     + {prod.p2, 32'd0}
                     + {prod.p3[31:0], 64'd0};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

endmodule

FILE: sv/fptc_format_stage.sv
// Picks the result fields out of the sum and carries whole units into the seconds.
module fptc_format_stage import fptc_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  sum_t    sum,
  output result_t result
);

  result_t result_next;

  always_comb begin
    result_next = '0;
    unique case (op_t'(sum.opcode))
      OP_MUL: begin
        result_next.fixed_value = sum.total[95:32];
      end
      OP_TO_NS, OP_TO_US: begin
        result_next.seconds = sum.seconds;
        result_next.subsec  = sum.total[32 +: SUBSEC_W];
      end
      OP_FROM_NS: begin
        result_next.fixed_value =
          {sum.seconds + 32'(sum.total[PROD_W-1 -: NS_QUOT_W]), sum.total[NS_SHIFT +: 32]};
      end
      OP_FROM_US, OP_US_TO_FIXED: begin
        result_next.fixed_value =
          {sum.seconds + 32'(sum.total[PROD_W-1 -: US_QUOT_W]), sum.total[US_SHIFT +: 32]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
